### rtl/e2q_pkg.sv
// e2q_pkg: fixed-point formats, lane types and the arctangent table shared by
// the Euler-to-quaternion pipeline cells and the top level. No dependencies.
package e2q_pkg;

    localparam int ZW       = 35;       // angle accumulator, Q.30 signed
    localparam int XW       = 33;       // CORDIC x/y, Q.30 signed
    localparam int SCW      = 23;       // sine/cosine and pair products, Q.20
    localparam int QW       = 23;       // raw quaternion components, Q.20
    localparam int MW       = 46;       // squared length, Q.40
    localparam int LW       = 24;       // length, Q.20
    localparam int SQ_CELLS = MW / 2;   // one root bit per cell
    localparam int HALF_POS = 33;       // input LSB weight to Q.30 half-angle

    localparam logic signed [ZW-1:0] ANG_PI      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 35'sd1686629713;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } cordic_lane_t;

    typedef cordic_lane_t [2:0] cordic_vec_t;

    typedef struct packed {
        logic [MW-1:0]        rem;
        logic [MW-1:0]        root;
        logic [3:0][QW-1:0]   q;
    } sqrt_t;

    // atan(2^-i) * 2^30, truncated
    function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:  r = 35'sd843314856;
            5'd1:  r = 35'sd497837829;
            5'd2:  r = 35'sd263043836;
            5'd3:  r = 35'sd133525158;
            5'd4:  r = 35'sd67021686;
            5'd5:  r = 35'sd33543515;
            5'd6:  r = 35'sd16775850;
            5'd7:  r = 35'sd8388437;
            5'd8:  r = 35'sd4194282;
            5'd9:  r = 35'sd2097149;
            5'd10: r = 35'sd1048575;
            5'd11: r = 35'sd524287;
            5'd12: r = 35'sd262143;
            5'd13: r = 35'sd131071;
            5'd14: r = 35'sd65535;
            5'd15: r = 35'sd32767;
            5'd16: r = 35'sd16383;
            5'd17: r = 35'sd8191;
            5'd18: r = 35'sd4095;
            5'd19: r = 35'sd2047;
            5'd20: r = 35'sd1023;
            5'd21: r = 35'sd511;
            5'd22: r = 35'sd255;
            5'd23: r = 35'sd127;
            5'd24: r = 35'sd63;
            5'd25: r = 35'sd31;
            5'd26: r = 35'sd15;
            5'd27: r = 35'sd7;
            5'd28: r = 35'sd3;
            5'd29: r = 35'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/e2q_cordic_cell.sv
// e2q_cordic_cell: one rotation-mode CORDIC iteration for all three angles.
// Depends on e2q_pkg.
module e2q_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  e2q_pkg::cordic_vec_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output e2q_pkg::cordic_vec_t out_data
);
    import e2q_pkg::*;

    localparam logic [4:0] TI = 5'(IDX % 32);

    logic        valid_reg, valid_next;
    cordic_vec_t data_reg, data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            data_next[k].neg = in_data[k].neg;
            if (!in_data[k].z[ZW-1])
            begin
                data_next[k].x = $signed(in_data[k].x) - ($signed(in_data[k].y) >>> IDX);
                data_next[k].y = $signed(in_data[k].y) + ($signed(in_data[k].x) >>> IDX);
                data_next[k].z = $signed(in_data[k].z) - atan_val(TI);
            end
            else
            begin
                data_next[k].x = $signed(in_data[k].x) + ($signed(in_data[k].y) >>> IDX);
                data_next[k].y = $signed(in_data[k].y) - ($signed(in_data[k].x) >>> IDX);
                data_next[k].z = $signed(in_data[k].z) + atan_val(TI);
            end
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

### rtl/e2q_sqrt_cell.sv
// e2q_sqrt_cell: one digit step of the floor integer square root.
// Depends on e2q_pkg.
module e2q_sqrt_cell #(
    parameter int K = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  e2q_pkg::sqrt_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output e2q_pkg::sqrt_t out_data
);
    import e2q_pkg::*;

    localparam logic [MW-1:0] BIT = MW'(1) << (2 * K);

    logic          valid_reg, valid_next;
    sqrt_t         data_reg, data_next;
    logic [MW-1:0] trial;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        trial       = in_data.root + BIT;
        data_next   = in_data;
        if (in_data.rem >= trial)
        begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = (in_data.root >> 1) + BIT;
        end
        else
        begin
            data_next.root = in_data.root >> 1;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

### rtl/e2q_div_cell.sv
// e2q_div_cell: one restoring-division quotient bit for all four components.
// Depends on e2q_pkg.
module e2q_div_cell #(
    parameter int CB = 16,
    parameter int P  = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [3:0][e2q_pkg::LW+CB:0]        in_rem,
    input  logic [3:0][CB:0]                    in_quo,
    input  logic [3:0]                          in_sgn,
    input  logic [e2q_pkg::LW-1:0]              in_len,
    input  logic                                in_zero,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [3:0][e2q_pkg::LW+CB:0]        out_rem,
    output logic [3:0][CB:0]                    out_quo,
    output logic [3:0]                          out_sgn,
    output logic [e2q_pkg::LW-1:0]              out_len,
    output logic                                out_zero
);
    import e2q_pkg::*;

    localparam int DW = LW + CB + 1;

    logic                valid_reg, valid_next;
    logic [3:0][DW-1:0]  rem_reg, rem_next;
    logic [3:0][CB:0]    quo_reg, quo_next;
    logic [3:0]          sgn_reg;
    logic [LW-1:0]       len_reg;
    logic                zero_reg;
    logic [DW-1:0]       dv;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_sgn   = sgn_reg;
    assign out_len   = len_reg;
    assign out_zero  = zero_reg;

    always_comb
    begin
        dv = DW'(in_len) << P;
        for (int k = 0; k < 4; k++)
        begin
            rem_next[k] = in_rem[k];
            quo_next[k] = in_quo[k];
            if (in_rem[k] >= dv)
            begin
                rem_next[k]    = in_rem[k] - dv;
                quo_next[k][P] = 1'b1;
            end
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            sgn_reg  <= in_sgn;
            len_reg  <= in_len;
            zero_reg <= in_zero;
        end
    end

endmodule

### rtl/euler_to_unit_quaternion.sv
// euler_to_unit_quaternion: top level of the Euler-angle to unit-quaternion pipeline.
// Depends on e2q_pkg, e2q_cordic_cell, e2q_sqrt_cell and e2q_div_cell.
//
// Usage:
//   Slave stream s_*: one transaction carries pitch, yaw and roll (signed
//   Q4.(ANGLE_BITS-4) radians). Master stream m_*: one transaction carries the
//   normalized quaternion w, x, y, z (signed Q1.(COMPONENT_BITS-2)), saturated
//   to plus or minus one; a zero-length quaternion comes out as w = 1.
//   Every accepted input yields exactly one output, in order.
//   Throughput: one transaction per cycle while m_tready stays high.
//   Chain of cells from acceptance to m_tvalid: angle prep, one cell per CORDIC
//   iteration, a sign-fix stage, four product/sum stages, 23 square-root digit
//   cells, a divide prep stage, COMPONENT_BITS + 1 quotient-bit cells and the
//   output register.
//   Every stage holds its own valid bit and moves forward when the next stage
//   is empty or moving, so bubbles close up while the receiver stalls; s_tready
//   drops only once the whole chain is full.
//   Reset (rst_n low, asynchronous) empties the chain; no clearing pass.
module euler_to_unit_quaternion #(
    parameter int ANGLE_BITS     = 16,
    parameter int COMPONENT_BITS = 16,
    parameter int CORDIC_STAGES  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // pitch_angle, yaw_angle, roll_angle, zero pad
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // quat_w, quat_x, quat_y, quat_z, zero pad
    output logic [((4*COMPONENT_BITS+7)/8)*8-1:0] m_tdata
);
    import e2q_pkg::*;

    localparam int AB    = ANGLE_BITS;
    localparam int CB    = COMPONENT_BITS;
    localparam int CS    = CORDIC_STAGES;
    localparam int OUT_W = ((4*CB+7)/8)*8;
    localparam int DW    = LW + CB + 1;
    localparam int PW    = 2 * SCW;
    localparam logic [CB:0] ONE = (CB+1)'(1) << (CB - 2);

    // ---------------- angle prep ----------------
    logic        prep_valid_reg;
    cordic_vec_t prep_reg, prep_next;
    logic        prep_ready;
    logic signed [ZW-1:0] hz [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            hz[k] = ZW'($signed(s_tdata[k*AB +: AB])) <<< (HALF_POS - AB);
            prep_next[k].x   = CORDIC_GAIN;
            prep_next[k].y   = '0;
            prep_next[k].z   = hz[k];
            prep_next[k].neg = 1'b0;
            if (hz[k] > ANG_HALF_PI)
            begin
                prep_next[k].z   = hz[k] - ANG_PI;
                prep_next[k].neg = 1'b1;
            end
            else if (hz[k] < -ANG_HALF_PI)
            begin
                prep_next[k].z   = hz[k] + ANG_PI;
                prep_next[k].neg = 1'b1;
            end
        end
    end

    logic crd_valid [CS+1];
    logic crd_ready [CS+1];
    cordic_vec_t crd_data [CS+1];

    assign s_tready    = !prep_valid_reg || crd_ready[0];
    assign prep_ready  = s_tready;
    assign crd_valid[0] = prep_valid_reg;
    assign crd_data[0]  = prep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (prep_ready)
            prep_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (prep_ready && s_tvalid)
            prep_reg <= prep_next;
    end

    // ---------------- CORDIC cells ----------------
    for (genvar i = 0; i < CS; i++)
    begin : g_cordic
        e2q_cordic_cell #(.IDX(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (crd_valid[i]),
            .in_ready  (crd_ready[i]),
            .in_data   (crd_data[i]),
            .out_valid (crd_valid[i+1]),
            .out_ready (crd_ready[i+1]),
            .out_data  (crd_data[i+1])
        );
    end

    // ---------------- sign fix and cut to Q.20 ----------------
    logic fix_valid_reg, fix_ready;
    logic signed [SCW-1:0] sc_reg [6];
    logic signed [SCW-1:0] sc_next [6];
    logic signed [XW-1:0]  fx [3];
    logic signed [XW-1:0]  fy [3];
    logic pair_ready;

    assign fix_ready      = !fix_valid_reg || pair_ready;
    assign crd_ready[CS]  = fix_ready;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fx[k] = crd_data[CS][k].neg ? -crd_data[CS][k].x : crd_data[CS][k].x;
            fy[k] = crd_data[CS][k].neg ? -crd_data[CS][k].y : crd_data[CS][k].y;
            sc_next[2*k]   = SCW'(fx[k] >>> 10);
            sc_next[2*k+1] = SCW'(fy[k] >>> 10);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fix_valid_reg <= 1'b0;
        else if (fix_ready)
            fix_valid_reg <= crd_valid[CS];
    end

    always_ff @(posedge clk)
    begin
        if (fix_ready && crd_valid[CS])
            sc_reg <= sc_next;
    end

    // ---------------- yaw/roll pair products ----------------
    logic pair_valid_reg;
    logic signed [SCW-1:0] pair_reg [4];   // cycr, sysr, cysr, sycr
    logic signed [SCW-1:0] cp_reg, sp_reg;
    logic signed [PW-1:0]  pp [4];
    logic comp_ready;

    assign pair_ready = !pair_valid_reg || comp_ready;

    always_comb
    begin
        pp[0] = sc_reg[2] * sc_reg[4];
        pp[1] = sc_reg[3] * sc_reg[5];
        pp[2] = sc_reg[2] * sc_reg[5];
        pp[3] = sc_reg[3] * sc_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_valid_reg <= 1'b0;
        else if (pair_ready)
            pair_valid_reg <= fix_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pair_ready && fix_valid_reg)
        begin
            for (int k = 0; k < 4; k++)
                pair_reg[k] <= SCW'(pp[k] >>> 20);
            cp_reg <= sc_reg[0];
            sp_reg <= sc_reg[1];
        end
    end

    // ---------------- components ----------------
    logic comp_valid_reg;
    logic signed [QW-1:0] comp_reg [4];
    logic signed [PW-1:0] cpp [8];
    logic signed [PW:0]   csum [4];
    logic sq_ready;

    assign comp_ready = !comp_valid_reg || sq_ready;

    always_comb
    begin
        cpp[0] = cp_reg * pair_reg[0];
        cpp[1] = sp_reg * pair_reg[1];
        cpp[2] = sp_reg * pair_reg[0];
        cpp[3] = cp_reg * pair_reg[1];
        cpp[4] = cp_reg * pair_reg[3];
        cpp[5] = sp_reg * pair_reg[2];
        cpp[6] = cp_reg * pair_reg[2];
        cpp[7] = sp_reg * pair_reg[3];
        csum[0] = (PW+1)'(cpp[0]) + (PW+1)'(cpp[1]);
        csum[1] = (PW+1)'(cpp[2]) - (PW+1)'(cpp[3]);
        csum[2] = (PW+1)'(cpp[4]) + (PW+1)'(cpp[5]);
        csum[3] = (PW+1)'(cpp[6]) - (PW+1)'(cpp[7]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            comp_valid_reg <= 1'b0;
        else if (comp_ready)
            comp_valid_reg <= pair_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (comp_ready && pair_valid_reg)
        begin
            for (int k = 0; k < 4; k++)
                comp_reg[k] <= QW'(csum[k] >>> 20);
        end
    end

    // ---------------- squares ----------------
    logic sq_valid_reg;
    logic [MW-1:0] sq_reg [4];
    logic [3:0][QW-1:0] sqq_reg;
    logic signed [2*QW-1:0] sqp [4];
    logic sum_ready;

    assign sq_ready = !sq_valid_reg || sum_ready;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            sqp[k] = comp_reg[k] * comp_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else if (sq_ready)
            sq_valid_reg <= comp_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready && comp_valid_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sq_reg[k]  <= MW'(unsigned'(sqp[k]));
                sqq_reg[k] <= comp_reg[k];
            end
        end
    end

    // ---------------- squared length into root chain ----------------
    logic  sqr_valid [SQ_CELLS+1];
    logic  sqr_ready [SQ_CELLS+1];
    sqrt_t sqr_data  [SQ_CELLS+1];
    logic  sum_valid_reg;
    sqrt_t sum_reg;

    assign sum_ready    = !sum_valid_reg || sqr_ready[0];
    assign sqr_valid[0] = sum_valid_reg;
    assign sqr_data[0]  = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_valid_reg <= 1'b0;
        else if (sum_ready)
            sum_valid_reg <= sq_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && sq_valid_reg)
        begin
            sum_reg.rem  <= sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
            sum_reg.root <= '0;
            sum_reg.q    <= sqq_reg;
        end
    end

    for (genvar j = 0; j < SQ_CELLS; j++)
    begin : g_sqrt
        e2q_sqrt_cell #(.K(SQ_CELLS - 1 - j)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sqr_valid[j]),
            .in_ready  (sqr_ready[j]),
            .in_data   (sqr_data[j]),
            .out_valid (sqr_valid[j+1]),
            .out_ready (sqr_ready[j+1]),
            .out_data  (sqr_data[j+1])
        );
    end

    // ---------------- divide prep: |q| * one + len/2 ----------------
    localparam int QB = CB + 1;

    logic               dv_valid [QB+1];
    logic               dv_ready [QB+1];
    logic [3:0][DW-1:0] dv_rem   [QB+1];
    logic [3:0][CB:0]   dv_quo   [QB+1];
    logic [3:0]         dv_sgn   [QB+1];
    logic [LW-1:0]      dv_len   [QB+1];
    logic               dv_zero  [QB+1];

    logic               dp_valid_reg, dp_ready;
    logic [3:0][DW-1:0] dp_rem_reg;
    logic [3:0]         dp_sgn_reg;
    logic [LW-1:0]      dp_len_reg, dp_len;
    logic               dp_zero_reg;
    logic [QW-1:0]      dp_mag [4];

    assign dp_ready  = !dp_valid_reg || dv_ready[0];
    assign sqr_ready[SQ_CELLS] = dp_ready;
    assign dp_len    = sqr_data[SQ_CELLS].root[LW-1:0];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            dp_mag[k] = sqr_data[SQ_CELLS].q[k][QW-1] ? -sqr_data[SQ_CELLS].q[k]
                                                      : sqr_data[SQ_CELLS].q[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dp_valid_reg <= 1'b0;
        else if (dp_ready)
            dp_valid_reg <= sqr_valid[SQ_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (dp_ready && sqr_valid[SQ_CELLS])
        begin
            for (int k = 0; k < 4; k++)
            begin
                dp_rem_reg[k] <= (DW'(dp_mag[k]) << (CB - 2)) + DW'(dp_len >> 1);
                dp_sgn_reg[k] <= sqr_data[SQ_CELLS].q[k][QW-1];
            end
            dp_len_reg  <= dp_len;
            dp_zero_reg <= (dp_len == '0);
        end
    end

    assign dv_valid[0] = dp_valid_reg;
    assign dv_rem[0]   = dp_rem_reg;
    assign dv_quo[0]   = '0;
    assign dv_sgn[0]   = dp_sgn_reg;
    assign dv_len[0]   = dp_len_reg;
    assign dv_zero[0]  = dp_zero_reg;

    // top quotient bit flags an overrange quotient
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        e2q_div_cell #(.CB(CB), .P(CB - j)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[j]),
            .in_ready  (dv_ready[j]),
            .in_rem    (dv_rem[j]),
            .in_quo    (dv_quo[j]),
            .in_sgn    (dv_sgn[j]),
            .in_len    (dv_len[j]),
            .in_zero   (dv_zero[j]),
            .out_valid (dv_valid[j+1]),
            .out_ready (dv_ready[j+1]),
            .out_rem   (dv_rem[j+1]),
            .out_quo   (dv_quo[j+1]),
            .out_sgn   (dv_sgn[j+1]),
            .out_len   (dv_len[j+1]),
            .out_zero  (dv_zero[j+1])
        );
    end

    // ---------------- saturate and output register ----------------
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;
    logic [CB:0]        sat [4];
    logic               out_ready;

    assign out_ready   = !out_valid_reg || m_tready;
    assign dv_ready[QB] = out_ready;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;

    always_comb
    begin
        out_data_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            sat[k] = (dv_quo[QB][k] > ONE) ? ONE : dv_quo[QB][k];
            if (dv_zero[QB])
                out_data_next[k*CB +: CB] = (k == 0) ? ONE[CB-1:0] : '0;
            else
                out_data_next[k*CB +: CB] = dv_sgn[QB][k] ? -sat[k][CB-1:0]
                                                          : sat[k][CB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= dv_valid[QB];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && dv_valid[QB])
            out_data_reg <= out_data_next;
    end

endmodule

### rtl/e2q_checker.sv
// e2q_checker: port-level assertions for euler_to_unit_quaternion, bound to the top.
// Depends on nothing but the top level's ports.
module e2q_checker #(
    parameter int COMPONENT_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((4*COMPONENT_BITS+7)/8)*8-1:0] m_tdata
);
    localparam int CB = COMPONENT_BITS;
    localparam logic signed [CB-1:0] ONE  = CB'(1) << (CB - 2);
    localparam logic signed [CB-1:0] MONE = -(CB'(1) << (CB - 2));

    logic signed [CB-1:0] comp [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            comp[k] = $signed(m_tdata[k*CB +: CB]);
    end

    // pipeline is empty in the cycle after reset is seen
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("m_tvalid high during reset");

    // stalled transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output changed");

    // a unit quaternion is never all zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (comp[0] != 0 || comp[1] != 0 || comp[2] != 0 || comp[3] != 0))
        else $error("all-zero quaternion");

    for (genvar k = 0; k < 4; k++)
    begin : g_range
        a_range: assert property (@(posedge clk) disable iff (!rst_n)
            m_tvalid |-> (comp[k] <= ONE && comp[k] >= MONE))
            else $error("component beyond unit range");
    end

endmodule

bind euler_to_unit_quaternion e2q_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_e2q_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
